@@ sv/assert_macros.svh @@
// Assertion macros used by the back end of the genotype concordance histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

@@ sv/gch_pkg.sv @@
// Shared constants, codes and item types of the genotype concordance histogram.
`default_nettype none
package gch_pkg;

    localparam int NSAMPLES_DEF     = 16;
    localparam int QUALITY_BINS_DEF = 128;
    localparam int COUNT_WIDTH_DEF  = 32;

    localparam int NKINDS    = 5;
    localparam int OPCODE_W  = 2;
    localparam int SAMPLE_W  = 5;
    localparam int BASE_W    = 2;
    localparam int QUAL_W    = 7;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int TKIND_W   = 2;
    localparam int OUT_CNT_W = 32;

    localparam logic [OPCODE_W-1:0] OP_COMPARE   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ_HIST = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ_CNT  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE      = 2'd3;

    localparam logic [STATUS_W-1:0] ST_COMPARED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_READ     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd3;

    localparam logic [KIND_W-1:0] KIND_OVERALL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HOMHOM  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HETHET  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HOMHET  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HETHOM  = 3'd4;

    typedef enum logic [2:0] {
        CMD_BAD,
        CMD_COMPARE,
        CMD_MISSING,
        CMD_READ_HIST,
        CMD_READ_CNT,
        CMD_READ_TOTAL
    } cmd_code_t;

    // Classified work item passed from the front end to the back end.
    typedef struct packed {
        cmd_code_t           code;
        logic [SAMPLE_W-1:0] sample;
        logic [KIND_W-1:0]   kind;
        logic [QUAL_W-1:0]   bin;
        logic                disc;
        logic                cell_ok;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 is_discordant;
        logic [TKIND_W-1:0]   transition_kind;
        logic [OUT_CNT_W-1:0] count_first;
        logic [OUT_CNT_W-1:0] count_second;
        logic [OUT_CNT_W-1:0] count_third;
    } result_t;

endpackage
`default_nettype wire

@@ sv/gch_queue.sv @@
// Two-entry queue of classified items between the front and back ends.
`default_nettype none
module gch_queue
    import gch_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  cmd_t      in_data,
    output logic      out_valid,
    input  wire logic out_pop,
    output cmd_t      out_data
);

    localparam int DEPTH = 2;

    cmd_t       entry_reg [DEPTH];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'(DEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = entry_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            priority if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/gch_front.sv @@
// Front end: accepts items, holds the binning register and classifies genotypes.
`default_nettype none
module gch_front
    import gch_pkg::*;
#(
    parameter int NSAMPLES     = NSAMPLES_DEF,
    parameter int QUALITY_BINS = QUALITY_BINS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_gq_binning_on,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [OPCODE_W-1:0] s_opcode,
    input  wire logic [SAMPLE_W-1:0] s_sample_index,
    input  wire logic [BASE_W-1:0]   s_truth_base_first,
    input  wire logic [BASE_W-1:0]   s_truth_base_second,
    input  wire logic [BASE_W-1:0]   s_call_base_first,
    input  wire logic [BASE_W-1:0]   s_call_base_second,
    input  wire logic                s_call_missing,
    input  wire logic [QUAL_W-1:0]   s_quality_score,
    input  wire logic [KIND_W-1:0]   s_kind_select,
    input  wire logic [QUAL_W-1:0]   s_bin_select,
    input  wire logic                s_discordant_select,
    input  wire logic                clear_done,
    output logic                     q_in_valid,
    input  wire logic                q_in_ready,
    output cmd_t                     q_in_data
);

    logic        gq_reg;
    logic [31:0] smp32;
    logic        truth_hom;
    logic        call_hom;
    logic [KIND_W-1:0] cmp_kind;
    logic        cmp_disc;
    logic [QUAL_W-1:0] cmp_bin;

    assign cfg_ready = 1'b1;
    assign s_ready   = q_in_ready && clear_done;
    // Unused opcodes are taken and dropped without a result.
    assign q_in_valid = s_valid && s_ready && (s_opcode != OP_NONE);
    assign smp32      = 32'(s_sample_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gq_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            gq_reg <= cfg_gq_binning_on;
        end
    end

    always_comb begin
        truth_hom = (s_truth_base_first == s_truth_base_second);
        call_hom  = (s_call_base_first == s_call_base_second);
        priority if (truth_hom && call_hom) begin
            cmp_kind = KIND_HOMHOM;
            cmp_disc = (s_truth_base_first != s_call_base_first);
        end else if (truth_hom) begin
            cmp_kind = KIND_HOMHET;
            cmp_disc = 1'b1;
        end else if (call_hom) begin
            cmp_kind = KIND_HETHOM;
            cmp_disc = 1'b1;
        end else begin
            cmp_kind = KIND_HETHET;
            cmp_disc = !(((s_truth_base_first == s_call_base_first) &&
                          (s_truth_base_second == s_call_base_second)) ||
                         ((s_truth_base_first == s_call_base_second) &&
                          (s_truth_base_second == s_call_base_first)));
        end
    end

    always_comb begin
        cmp_bin = '0;
        if (gq_reg) begin
            cmp_bin = (32'(s_quality_score) >= QUALITY_BINS) ?
                      QUAL_W'(QUALITY_BINS - 1) : s_quality_score;
        end
    end

    always_comb begin
        q_in_data         = '0;
        q_in_data.code    = CMD_BAD;
        q_in_data.sample  = s_sample_index;
        unique case (s_opcode)
            OP_COMPARE: begin
                q_in_data.kind = cmp_kind;
                q_in_data.bin  = cmp_bin;
                q_in_data.disc = cmp_disc;
                priority if (smp32 >= 32'(NSAMPLES)) begin
                    q_in_data.code = CMD_BAD;
                end else if (s_call_missing) begin
                    q_in_data.code = CMD_MISSING;
                end else begin
                    q_in_data.code = CMD_COMPARE;
                end
            end
            OP_READ_HIST: begin
                q_in_data.kind    = s_kind_select;
                q_in_data.bin     = s_bin_select;
                q_in_data.disc    = s_discordant_select;
                q_in_data.cell_ok = (s_kind_select <= KIND_HETHOM) &&
                                    (32'(s_bin_select) < QUALITY_BINS);
                q_in_data.code    = (smp32 > 32'(NSAMPLES)) ? CMD_BAD : CMD_READ_HIST;
            end
            OP_READ_CNT: begin
                priority if (smp32 > 32'(NSAMPLES)) begin
                    q_in_data.code = CMD_BAD;
                end else if (smp32 == 32'(NSAMPLES)) begin
                    q_in_data.code = CMD_READ_TOTAL;
                end else begin
                    q_in_data.code = CMD_READ_CNT;
                end
            end
            OP_NONE: begin
                q_in_data.code = CMD_BAD;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/gch_back.sv @@
// Back end: histogram and counter memories, read-modify-write sequencer, result register.
`default_nettype none
`include "assert_macros.svh"
module gch_back
    import gch_pkg::*;
#(
    parameter int NSAMPLES     = NSAMPLES_DEF,
    parameter int QUALITY_BINS = QUALITY_BINS_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    input  cmd_t      q_data,
    output logic      q_pop,
    output logic      clear_done,
    output logic      m_valid,
    input  wire logic m_ready,
    output result_t   m_result
);

    localparam int HIST_DEPTH = (NSAMPLES + 1) * NKINDS * QUALITY_BINS * 2;
    localparam int HADDR_W    = $clog2(HIST_DEPTH);
    localparam int CADDR_W    = (NSAMPLES > 1) ? $clog2(NSAMPLES) : 1;
    localparam int TOT_W      = $clog2(NSAMPLES + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CMP,
        S_MISS,
        S_HREAD,
        S_CREAD,
        S_TOTAL,
        S_OUT
    } state_t;

    function automatic logic [HADDR_W-1:0] hist_addr(input logic [31:0] smp,
                                                     input logic [KIND_W-1:0] kind,
                                                     input logic [QUAL_W-1:0] bin,
                                                     input logic disc);
        return HADDR_W'((((smp * 32'(NKINDS)) + 32'(kind)) * 32'(QUALITY_BINS) +
                         32'(bin)) * 32'd2 + 32'(disc));
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                       input logic [COUNT_WIDTH-1:0] b);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    endfunction

    // Counters wider than the result fields are returned modulo 2^32.
    function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+OUT_CNT_W-1:0] ext;
        ext = {{OUT_CNT_W{1'b0}}, v};
        return ext[OUT_CNT_W-1:0];
    endfunction

    state_t                 state_reg;
    cmd_t                   cmd_reg;
    logic [1:0]             step_reg;
    logic [HADDR_W-1:0]     clr_reg;
    logic [HADDR_W-1:0]     last_ra_reg;
    logic [TOT_W-1:0]       tot_reg;
    logic [COUNT_WIDTH-1:0] acc_cmp_reg;
    logic [COUNT_WIDTH-1:0] acc_miss_reg;
    logic [COUNT_WIDTH-1:0] acc_disc_reg;
    result_t                res_reg;
    result_t                out_reg;
    logic                   out_valid_reg;

    logic [COUNT_WIDTH-1:0] hist_mem [HIST_DEPTH];
    logic [COUNT_WIDTH-1:0] cmp_mem  [NSAMPLES];
    logic [COUNT_WIDTH-1:0] miss_mem [NSAMPLES];
    logic [COUNT_WIDTH-1:0] disc_mem [NSAMPLES];
    logic [COUNT_WIDTH-1:0] hist_q_reg;
    logic [COUNT_WIDTH-1:0] cmp_q_reg;
    logic [COUNT_WIDTH-1:0] miss_q_reg;
    logic [COUNT_WIDTH-1:0] disc_q_reg;

    logic                   clearing;
    logic                   hist_re;
    logic [HADDR_W-1:0]     hist_ra;
    logic                   hist_we;
    logic [HADDR_W-1:0]     hist_wa;
    logic [COUNT_WIDTH-1:0] hist_wd;
    logic                   cnt_re;
    logic [CADDR_W-1:0]     cnt_ra;
    logic [CADDR_W-1:0]     cnt_wa;
    logic                   cmp_we;
    logic                   miss_we;
    logic                   disc_we;
    logic [COUNT_WIDTH-1:0] cmp_wd;
    logic [COUNT_WIDTH-1:0] miss_wd;
    logic [COUNT_WIDTH-1:0] disc_wd;
    logic [HADDR_W-1:0]     step_addr;
    logic [COUNT_WIDTH-1:0] acc_cmp_next;
    logic [COUNT_WIDTH-1:0] acc_miss_next;
    logic [COUNT_WIDTH-1:0] acc_disc_next;

    assign clearing   = (state_reg == S_CLEAR);
    assign clear_done = !clearing;
    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign m_valid    = out_valid_reg;
    assign m_result   = out_reg;

    assign acc_cmp_next  = sat_add(acc_cmp_reg, cmp_q_reg);
    assign acc_miss_next = sat_add(acc_miss_reg, miss_q_reg);
    assign acc_disc_next = sat_add(acc_disc_reg, disc_q_reg);

    // Compare updates four cells: sample overall, sample by kind, total overall,
    // total by kind. Step k reads cell k+1 while writing back cell k.
    always_comb begin
        unique case (step_reg)
            2'd0: step_addr = hist_addr(32'(cmd_reg.sample), cmd_reg.kind,
                                        cmd_reg.bin, cmd_reg.disc);
            2'd1: step_addr = hist_addr(32'(NSAMPLES), KIND_OVERALL,
                                        cmd_reg.bin, cmd_reg.disc);
            2'd2: step_addr = hist_addr(32'(NSAMPLES), cmd_reg.kind,
                                        cmd_reg.bin, cmd_reg.disc);
            2'd3: step_addr = hist_addr(32'(NSAMPLES), cmd_reg.kind,
                                        cmd_reg.bin, cmd_reg.disc);
        endcase
    end

    always_comb begin
        hist_re = 1'b0;
        hist_ra = '0;
        hist_we = 1'b0;
        hist_wa = last_ra_reg;
        hist_wd = sat_inc(hist_q_reg);
        cnt_re  = 1'b0;
        cnt_ra  = CADDR_W'(cmd_reg.sample);
        cnt_wa  = CADDR_W'(cmd_reg.sample);
        cmp_we  = 1'b0;
        miss_we = 1'b0;
        disc_we = 1'b0;
        cmp_wd  = clearing ? '0 : sat_inc(cmp_q_reg);
        miss_wd = clearing ? '0 : sat_inc(miss_q_reg);
        disc_wd = clearing ? '0 : sat_inc(disc_q_reg);
        unique case (state_reg)
            S_CLEAR: begin
                hist_we = 1'b1;
                hist_wa = clr_reg;
                hist_wd = '0;
                cnt_wa  = CADDR_W'(clr_reg);
                if (32'(clr_reg) < 32'(NSAMPLES)) begin
                    cmp_we  = 1'b1;
                    miss_we = 1'b1;
                    disc_we = 1'b1;
                end
            end
            S_IDLE: begin
                cnt_ra = CADDR_W'(q_data.sample);
                if (q_valid) begin
                    unique case (q_data.code)
                        CMD_COMPARE: begin
                            hist_re = 1'b1;
                            hist_ra = hist_addr(32'(q_data.sample), KIND_OVERALL,
                                                q_data.bin, q_data.disc);
                            cnt_re  = 1'b1;
                        end
                        CMD_MISSING, CMD_READ_CNT: begin
                            cnt_re = 1'b1;
                        end
                        CMD_READ_HIST: begin
                            hist_re = q_data.cell_ok;
                            hist_ra = hist_addr(32'(q_data.sample), q_data.kind,
                                                q_data.bin, q_data.disc);
                        end
                        CMD_READ_TOTAL: begin
                            cnt_re = 1'b1;
                            cnt_ra = '0;
                        end
                        default: begin
                            cnt_re = 1'b0;
                        end
                    endcase
                end
            end
            S_CMP: begin
                hist_we = 1'b1;
                hist_re = (step_reg != 2'd3);
                hist_ra = step_addr;
                if (step_reg == 2'd0) begin
                    cmp_we  = 1'b1;
                    disc_we = cmd_reg.disc;
                end
            end
            S_MISS: begin
                miss_we = 1'b1;
            end
            S_TOTAL: begin
                cnt_ra = CADDR_W'(tot_reg);
                cnt_re = (32'(tot_reg) < 32'(NSAMPLES));
            end
            S_HREAD, S_CREAD, S_OUT: begin
                hist_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (hist_re) begin
            hist_q_reg  <= hist_mem[hist_ra];
            last_ra_reg <= hist_ra;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_we) begin
            cmp_mem[cnt_wa] <= cmp_wd;
        end
        if (miss_we) begin
            miss_mem[cnt_wa] <= miss_wd;
        end
        if (disc_we) begin
            disc_mem[cnt_wa] <= disc_wd;
        end
        if (cnt_re) begin
            cmp_q_reg  <= cmp_mem[cnt_ra];
            miss_q_reg <= miss_mem[cnt_ra];
            disc_q_reg <= disc_mem[cnt_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // In S_OUT the result stage sets the valid flag on its own.
            if (out_valid_reg && m_ready && (state_reg != S_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    if (clr_reg == HADDR_W'(HIST_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        clr_reg <= clr_reg + HADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg  <= q_data;
                        step_reg <= 2'd0;
                        unique case (q_data.code)
                            CMD_COMPARE: begin
                                res_reg   <= '0;
                                state_reg <= S_CMP;
                            end
                            CMD_MISSING: begin
                                res_reg   <= '0;
                                state_reg <= S_MISS;
                            end
                            CMD_READ_HIST: begin
                                res_reg   <= '0;
                                state_reg <= S_HREAD;
                            end
                            CMD_READ_CNT: begin
                                res_reg   <= '0;
                                state_reg <= S_CREAD;
                            end
                            CMD_READ_TOTAL: begin
                                res_reg      <= '0;
                                acc_cmp_reg  <= '0;
                                acc_miss_reg <= '0;
                                acc_disc_reg <= '0;
                                tot_reg      <= TOT_W'(1);
                                state_reg    <= S_TOTAL;
                            end
                            default: begin
                                res_reg   <= {ST_BAD, {($bits(result_t) - STATUS_W){1'b0}}};
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CMP: begin
                    if (step_reg == 2'd3) begin
                        res_reg.status          <= ST_COMPARED;
                        res_reg.is_discordant   <= cmd_reg.disc;
                        res_reg.transition_kind <= TKIND_W'(cmd_reg.kind - KIND_HOMHOM);
                        state_reg               <= S_OUT;
                    end else begin
                        step_reg <= step_reg + 2'd1;
                    end
                end
                S_MISS: begin
                    res_reg.status <= ST_MISSING;
                    state_reg      <= S_OUT;
                end
                S_HREAD: begin
                    res_reg.status      <= ST_READ;
                    res_reg.count_first <= cmd_reg.cell_ok ? to_out(hist_q_reg) : '0;
                    state_reg           <= S_OUT;
                end
                S_CREAD: begin
                    res_reg.status       <= ST_READ;
                    res_reg.count_first  <= to_out(cmp_q_reg);
                    res_reg.count_second <= to_out(miss_q_reg);
                    res_reg.count_third  <= to_out(disc_q_reg);
                    state_reg            <= S_OUT;
                end
                S_TOTAL: begin
                    acc_cmp_reg  <= acc_cmp_next;
                    acc_miss_reg <= acc_miss_next;
                    acc_disc_reg <= acc_disc_next;
                    if (32'(tot_reg) == 32'(NSAMPLES)) begin
                        res_reg.status       <= ST_READ;
                        res_reg.count_first  <= to_out(acc_cmp_next);
                        res_reg.count_second <= to_out(acc_miss_next);
                        res_reg.count_third  <= to_out(acc_disc_next);
                        state_reg            <= S_OUT;
                    end else begin
                        tot_reg <= tot_reg + TOT_W'(1);
                    end
                end
                S_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    `ASSERT_NEVER(a_rmw_no_alias, aclk, aresetn, (state_reg == S_CMP) && hist_re && hist_we && (hist_ra == hist_wa))
    `ASSERT_PROP(a_clear_full_sweep, aclk, aresetn, ((state_reg == S_IDLE) && ($past(state_reg) == S_CLEAR)) |-> ($past(clr_reg) == HADDR_W'(HIST_DEPTH - 1)))
    `ASSERT_PROP(a_result_waits, aclk, aresetn, ((state_reg == S_OUT) && out_valid_reg && !m_ready) |=> (state_reg == S_OUT))
    `ASSERT_PROP(a_total_bound, aclk, aresetn, (state_reg == S_TOTAL) |-> ((32'(tot_reg) >= 32'd1) && (32'(tot_reg) <= 32'(NSAMPLES))))

endmodule
`default_nettype wire

@@ sv/genotype_concordance_histogram.sv @@
// A compare keeps the back end busy while its four histogram read-modify-writes go
// through the one histogram memory in turn; the back end takes no new item until the
// current result has been passed to the result register, and a total counter read
// sums the per-sample counters one sample after another.
// Reset clears all (NSAMPLES+1)*10*QUALITY_BINS histogram cells (21760 by default)
// with s_ready low; configuration writes are taken during the pass.
`default_nettype none
module genotype_concordance_histogram
    import gch_pkg::*;
#(
    parameter int NSAMPLES     = NSAMPLES_DEF,
    parameter int QUALITY_BINS = QUALITY_BINS_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_gq_binning_on,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OPCODE_W-1:0]  s_opcode,
    input  wire logic [SAMPLE_W-1:0]  s_sample_index,
    input  wire logic [BASE_W-1:0]    s_truth_base_first,
    input  wire logic [BASE_W-1:0]    s_truth_base_second,
    input  wire logic [BASE_W-1:0]    s_call_base_first,
    input  wire logic [BASE_W-1:0]    s_call_base_second,
    input  wire logic                 s_call_missing,
    input  wire logic [QUAL_W-1:0]    s_quality_score,
    input  wire logic [KIND_W-1:0]    s_kind_select,
    input  wire logic [QUAL_W-1:0]    s_bin_select,
    input  wire logic                 s_discordant_select,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic                      m_is_discordant,
    output logic [TKIND_W-1:0]        m_transition_kind,
    output logic [OUT_CNT_W-1:0]      m_count_first,
    output logic [OUT_CNT_W-1:0]      m_count_second,
    output logic [OUT_CNT_W-1:0]      m_count_third
);

    logic    clear_done;
    logic    q_in_valid;
    logic    q_in_ready;
    cmd_t    q_in_data;
    logic    q_out_valid;
    logic    q_out_pop;
    cmd_t    q_out_data;
    result_t result;

    gch_front #(
        .NSAMPLES     (NSAMPLES),
        .QUALITY_BINS (QUALITY_BINS)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_gq_binning_on   (cfg_gq_binning_on),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_sample_index      (s_sample_index),
        .s_truth_base_first  (s_truth_base_first),
        .s_truth_base_second (s_truth_base_second),
        .s_call_base_first   (s_call_base_first),
        .s_call_base_second  (s_call_base_second),
        .s_call_missing      (s_call_missing),
        .s_quality_score     (s_quality_score),
        .s_kind_select       (s_kind_select),
        .s_bin_select        (s_bin_select),
        .s_discordant_select (s_discordant_select),
        .clear_done          (clear_done),
        .q_in_valid          (q_in_valid),
        .q_in_ready          (q_in_ready),
        .q_in_data           (q_in_data)
    );

    gch_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_pop   (q_out_pop),
        .out_data  (q_out_data)
    );

    gch_back #(
        .NSAMPLES     (NSAMPLES),
        .QUALITY_BINS (QUALITY_BINS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_out_valid),
        .q_data     (q_out_data),
        .q_pop      (q_out_pop),
        .clear_done (clear_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (result)
    );

    assign m_status          = result.status;
    assign m_is_discordant   = result.is_discordant;
    assign m_transition_kind = result.transition_kind;
    assign m_count_first     = result.count_first;
    assign m_count_second    = result.count_second;
    assign m_count_third     = result.count_third;

endmodule
`default_nettype wire

@@ verif/genotype_concordance_histogram_tb.sv @@
// Self-checking testbench for the genotype concordance histogram block.
`timescale 1ns / 1ps

module genotype_concordance_histogram_tb;
    import gch_pkg::*;

    localparam int NSAMP = NSAMPLES_DEF;
    localparam int QBINS = QUALITY_BINS_DEF;
    localparam int CELLS = (NSAMP + 1) * NKINDS * QBINS * 2;
    localparam logic [OUT_CNT_W-1:0] COUNT_MAX = '1;
    localparam int SAMPLE_TOP = (1 << SAMPLE_W) - 1;

    localparam int BASE_A = 0;
    localparam int BASE_C = 1;
    localparam int BASE_G = 2;
    localparam int BASE_T = 3;

    // The slowest item to produce a result is a total counter read.
    localparam int DRAIN_CYCLES    = 40;
    localparam int PRESSURE_CYCLES = 300;
    localparam int PRESSURE_AFTER  = 150;
    // Covers the clearing pass over all 21760 histogram cells plus about 1550 items.
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SAMPLE_W-1:0] sample;
        logic [BASE_W-1:0]   truth_a;
        logic [BASE_W-1:0]   truth_b;
        logic [BASE_W-1:0]   call_a;
        logic [BASE_W-1:0]   call_b;
        logic                missing;
        logic [QUAL_W-1:0]   quality;
        logic [KIND_W-1:0]   kind_sel;
        logic [QUAL_W-1:0]   bin_sel;
        logic                disc_sel;
    } genotype_item_t;

    class concordance_scoreboard;
        bit [OUT_CNT_W-1:0] histogram [CELLS];
        bit [OUT_CNT_W-1:0] compared_cnt [NSAMP];
        bit [OUT_CNT_W-1:0] missing_cnt [NSAMP];
        bit [OUT_CNT_W-1:0] discordant_cnt [NSAMP];
        bit                 binning;
        result_t            expected_results [$];
        int                 failures;
        int                 results_checked;

        function bit [OUT_CNT_W-1:0] sat_inc(bit [OUT_CNT_W-1:0] v);
            return (v == COUNT_MAX) ? v : v + 1'b1;
        endfunction

        function int cell_index(int smp, int kind, int bin, bit disc);
            return (((smp * NKINDS) + kind) * QBINS + bin) * 2 + disc;
        endfunction

        function void bump(int smp, int kind, int bin, bit disc);
            int idx;
            idx = cell_index(smp, kind, bin, disc);
            histogram[idx] = sat_inc(histogram[idx]);
        endfunction

        // Updates the tracked state and returns 1 when the item produces a result.
        function bit concordance_outcome(genotype_item_t it, output result_t r);
            logic [KIND_W-1:0] kind;
            bit                disc;
            int                bin;
            logic [63:0]       cc, mc, dc;
            r = '0;
            if (it.opcode == OP_NONE) return 0;
            if (it.opcode == OP_COMPARE) begin
                if (it.sample >= NSAMP) begin
                    r.status = ST_BAD;
                    return 1;
                end
                if (it.missing) begin
                    missing_cnt[it.sample] = sat_inc(missing_cnt[it.sample]);
                    r.status = ST_MISSING;
                    return 1;
                end
                if (it.truth_a == it.truth_b && it.call_a == it.call_b) begin
                    kind = KIND_HOMHOM;
                    disc = (it.truth_a != it.call_a);
                end else if (it.truth_a == it.truth_b) begin
                    kind = KIND_HOMHET;
                    disc = 1'b1;
                end else if (it.call_a == it.call_b) begin
                    kind = KIND_HETHOM;
                    disc = 1'b1;
                end else begin
                    // Unphased: a het pair matches in either allele order.
                    kind = KIND_HETHET;
                    disc = !((it.truth_a == it.call_a && it.truth_b == it.call_b) ||
                             (it.truth_a == it.call_b && it.truth_b == it.call_a));
                end
                compared_cnt[it.sample] = sat_inc(compared_cnt[it.sample]);
                if (disc) discordant_cnt[it.sample] = sat_inc(discordant_cnt[it.sample]);
                bin = 0;
                if (binning) bin = (it.quality >= QBINS) ? QBINS - 1 : it.quality;
                bump(it.sample, KIND_OVERALL, bin, disc);
                bump(it.sample, kind, bin, disc);
                bump(NSAMP, KIND_OVERALL, bin, disc);
                bump(NSAMP, kind, bin, disc);
                r.status          = ST_COMPARED;
                r.is_discordant   = disc;
                r.transition_kind = TKIND_W'(kind - KIND_HOMHOM);
                return 1;
            end
            if (it.sample > NSAMP) begin
                r.status = ST_BAD;
                return 1;
            end
            r.status = ST_READ;
            if (it.opcode == OP_READ_HIST) begin
                if (it.kind_sel < NKINDS && it.bin_sel < QBINS)
                    r.count_first = histogram[cell_index(it.sample, it.kind_sel, it.bin_sel,
                                                         it.disc_sel)];
                return 1;
            end
            if (it.sample < NSAMP) begin
                r.count_first  = compared_cnt[it.sample];
                r.count_second = missing_cnt[it.sample];
                r.count_third  = discordant_cnt[it.sample];
            end else begin
                // Summing in 64 bits and clamping once equals a saturating running sum.
                cc = 0;
                mc = 0;
                dc = 0;
                for (int s = 0; s < NSAMP; s++) begin
                    cc += compared_cnt[s];
                    mc += missing_cnt[s];
                    dc += discordant_cnt[s];
                end
                r.count_first  = (cc > COUNT_MAX) ? COUNT_MAX : cc[OUT_CNT_W-1:0];
                r.count_second = (mc > COUNT_MAX) ? COUNT_MAX : mc[OUT_CNT_W-1:0];
                r.count_third  = (dc > COUNT_MAX) ? COUNT_MAX : dc[OUT_CNT_W-1:0];
            end
            return 1;
        endfunction

        function void accept_item(genotype_item_t it);
            result_t r;
            if (concordance_outcome(it, r)) expected_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_checked++;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result with no item pending: status %0d disc %0b kind %0d",
                             got.status, got.is_discordant, got.transition_kind);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.is_discordant !== want.is_discordant ||
                got.transition_kind !== want.transition_kind ||
                got.count_first !== want.count_first ||
                got.count_second !== want.count_second ||
                got.count_third !== want.count_third) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch at %0t: expected status %0d disc %0b kind %0d counts %0d %0d %0d",
                             $realtime, want.status, want.is_discordant, want.transition_kind,
                             want.count_first, want.count_second, want.count_third);
                    $display("                 actual status %0d disc %0b kind %0d counts %0d %0d %0d",
                             got.status, got.is_discordant, got.transition_kind,
                             got.count_first, got.count_second, got.count_third);
                end
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_gq_binning_on;
    logic                 s_valid;
    logic                 s_ready;
    logic [OPCODE_W-1:0]  s_opcode;
    logic [SAMPLE_W-1:0]  s_sample_index;
    logic [BASE_W-1:0]    s_truth_base_first;
    logic [BASE_W-1:0]    s_truth_base_second;
    logic [BASE_W-1:0]    s_call_base_first;
    logic [BASE_W-1:0]    s_call_base_second;
    logic                 s_call_missing;
    logic [QUAL_W-1:0]    s_quality_score;
    logic [KIND_W-1:0]    s_kind_select;
    logic [QUAL_W-1:0]    s_bin_select;
    logic                 s_discordant_select;
    logic                 m_valid;
    logic                 m_ready;
    logic [STATUS_W-1:0]  m_status;
    logic                 m_is_discordant;
    logic [TKIND_W-1:0]   m_transition_kind;
    logic [OUT_CNT_W-1:0] m_count_first;
    logic [OUT_CNT_W-1:0] m_count_second;
    logic [OUT_CNT_W-1:0] m_count_third;

    concordance_scoreboard tracker = new();
    int          idle_pct = 20;
    bit          pressure_done = 0;
    int unsigned cycle_count = 0;

    genotype_concordance_histogram i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(result_t'{m_status, m_is_discordant, m_transition_kind,
                                           m_count_first, m_count_second, m_count_third});
    end

    // Result side: random stalls, plus one long hold-off that backs the block up.
    initial begin : receiver
        int stall;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!pressure_done && tracker.results_checked >= PRESSURE_AFTER) begin
                m_ready <= 1'b0;
                stall = PRESSURE_CYCLES;
                pressure_done = 1;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                stall = $urandom_range(1, 6);
            end else begin
                m_ready <= 1'b1;
                stall = 1;
            end
            repeat (stall - 1) @(posedge aclk);
        end
    end

    task automatic present(input genotype_item_t it);
        s_opcode            <= it.opcode;
        s_sample_index      <= it.sample;
        s_truth_base_first  <= it.truth_a;
        s_truth_base_second <= it.truth_b;
        s_call_base_first   <= it.call_a;
        s_call_base_second  <= it.call_b;
        s_call_missing      <= it.missing;
        s_quality_score     <= it.quality;
        s_kind_select       <= it.kind_sel;
        s_bin_select        <= it.bin_sel;
        s_discordant_select <= it.disc_sel;
    endtask

    // Called at a rising edge; returns at the edge where the item is accepted.
    task automatic drive_item(input genotype_item_t it);
        present(it);
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        tracker.accept_item(it);
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic write_binning(input logic value);
        cfg_gq_binning_on <= value;
        cfg_valid         <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.binning = value;
    endtask

    // Waits with s_valid low for every pending result, then idles before the next phase.
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic genotype_item_t make_item(int op, int smp, int ta, int tb, int ca,
                                                 int cb, int miss, int q, int ks, int bs,
                                                 int ds);
        genotype_item_t it;
        it.opcode   = OPCODE_W'(op);
        it.sample   = SAMPLE_W'(smp);
        it.truth_a  = BASE_W'(ta);
        it.truth_b  = BASE_W'(tb);
        it.call_a   = BASE_W'(ca);
        it.call_b   = BASE_W'(cb);
        it.missing  = miss[0];
        it.quality  = QUAL_W'(q);
        it.kind_sel = KIND_W'(ks);
        it.bin_sel  = QUAL_W'(bs);
        it.disc_sel = ds[0];
        return it;
    endfunction

    // Reads and compares cluster on a few bins so that histogram reads find counts.
    function automatic logic [QUAL_W-1:0] hot_bin();
        case ($urandom_range(0, 6))
            0: return QUAL_W'(0);
            1: return QUAL_W'(1);
            2: return QUAL_W'(2);
            3: return QUAL_W'(QBINS / 2 - 1);
            4: return QUAL_W'(QBINS / 2);
            5: return QUAL_W'(QBINS - 2);
            default: return QUAL_W'(QBINS - 1);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] read_sample();
        if ($urandom_range(0, 99) < 5) return SAMPLE_W'($urandom_range(NSAMP + 1, SAMPLE_TOP));
        return SAMPLE_W'($urandom_range(0, NSAMP));
    endfunction

    function automatic genotype_item_t random_item();
        genotype_item_t it;
        logic [63:0]    bits;
        int             pick;
        logic [BASE_W-1:0] tmp;
        bits = {$urandom, $urandom};
        it = bits[$bits(genotype_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            it.opcode = OP_COMPARE;
            if ($urandom_range(0, 99) < 4)
                it.sample = SAMPLE_W'($urandom_range(NSAMP, SAMPLE_TOP));
            else
                it.sample = SAMPLE_W'($urandom_range(0, NSAMP - 1));
            it.missing = ($urandom_range(0, 99) < 10);
            if ($urandom_range(0, 99) < 35) it.truth_b = it.truth_a;
            if ($urandom_range(0, 99) < 45) begin
                it.call_a = it.truth_a;
                it.call_b = it.truth_b;
                if ($urandom_range(0, 1)) begin
                    tmp = it.call_a;
                    it.call_a = it.call_b;
                    it.call_b = tmp;
                end
            end else if ($urandom_range(0, 99) < 35) begin
                it.call_b = it.call_a;
            end
            if ($urandom_range(0, 1)) it.quality = hot_bin();
        end else if (pick < 80) begin
            it.opcode = OP_READ_HIST;
            it.sample = read_sample();
            if ($urandom_range(0, 99) >= 8) it.kind_sel = KIND_W'($urandom_range(0, NKINDS - 1));
            if ($urandom_range(0, 99) < 80) it.bin_sel = hot_bin();
        end else if (pick < 96) begin
            it.opcode = OP_READ_CNT;
            it.sample = read_sample();
        end else begin
            it.opcode = OP_NONE;
        end
        return it;
    endfunction

    task automatic run_directed();
        genotype_item_t plan [$];
        plan.push_back(make_item(OP_COMPARE, 0, BASE_A, BASE_A, BASE_A, BASE_A, 0, 0, 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, 0, BASE_T, BASE_T, BASE_G, BASE_G, 0, 127, 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, 1, BASE_A, BASE_C, BASE_C, BASE_A, 0, 64, 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, NSAMP - 1, BASE_G, BASE_T, BASE_G, BASE_T, 0, 63,
                                 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, 2, BASE_A, BASE_C, BASE_A, BASE_G, 0, 1, 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, 3, BASE_C, BASE_C, BASE_C, BASE_G, 0, 127, 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, 3, BASE_A, BASE_T, BASE_T, BASE_T, 0, 0, 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, NSAMP - 1, BASE_T, BASE_T, BASE_T, BASE_T, 1, 127,
                                 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, 0, BASE_A, BASE_C, BASE_G, BASE_T, 1, 0, 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, NSAMP, BASE_A, BASE_A, BASE_A, BASE_A, 0, 5,
                                 0, 0, 0));
        plan.push_back(make_item(OP_COMPARE, SAMPLE_TOP, BASE_T, BASE_T, BASE_T, BASE_T, 1, 127,
                                 7, 127, 1));
        plan.push_back(make_item(OP_NONE, SAMPLE_TOP, BASE_T, BASE_T, BASE_T, BASE_T, 1, 127,
                                 7, 127, 1));
        plan.push_back(make_item(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(make_item(OP_READ_HIST, 0, 0, 0, 0, 0, 0, 0, KIND_OVERALL, 0, 0));
        plan.push_back(make_item(OP_READ_HIST, NSAMP, 0, 0, 0, 0, 0, 0, KIND_OVERALL, 127, 1));
        plan.push_back(make_item(OP_READ_HIST, 0, 0, 0, 0, 0, 0, 0, KIND_HOMHOM, 127, 1));
        plan.push_back(make_item(OP_READ_HIST, 1, 0, 0, 0, 0, 0, 0, KIND_HETHET, 64, 0));
        plan.push_back(make_item(OP_READ_HIST, 2, 0, 0, 0, 0, 0, 0, KIND_HETHET, 1, 1));
        plan.push_back(make_item(OP_READ_HIST, 3, 0, 0, 0, 0, 0, 0, KIND_HOMHET, 127, 1));
        plan.push_back(make_item(OP_READ_HIST, 3, 0, 0, 0, 0, 0, 0, KIND_HETHOM, 0, 1));
        plan.push_back(make_item(OP_READ_HIST, 0, 0, 0, 0, 0, 0, 0, KIND_HETHOM + 1, 0, 0));
        plan.push_back(make_item(OP_READ_HIST, NSAMP, 3, 3, 3, 3, 1, 127, 7, 127, 1));
        plan.push_back(make_item(OP_READ_HIST, NSAMP + 1, 0, 0, 0, 0, 0, 0, KIND_OVERALL, 0, 0));
        plan.push_back(make_item(OP_READ_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(make_item(OP_READ_CNT, NSAMP - 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(make_item(OP_READ_CNT, NSAMP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(make_item(OP_READ_CNT, SAMPLE_TOP, 3, 3, 3, 3, 1, 127, 7, 127, 1));
        foreach (plan[i]) begin
            sender_gap();
            drive_item(plan[i]);
        end
    endtask

    task automatic run_random(input int count, input bit quiet);
        for (int n = 0; n < count; n++) begin
            // Idling density changes in stretches, including stretches with none.
            if (quiet) begin
                idle_pct = 0;
            end else if (n % 128 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 12;
                    default: idle_pct = 40;
                endcase
            end
            sender_gap();
            drive_item(random_item());
        end
    endtask

    initial begin
        present('0);
        s_valid           <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_gq_binning_on <= 1'b0;
        aresetn           <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        write_binning(1'b1);
        run_directed();
        settle();
        write_binning(1'b0);
        run_random(400, 1'b0);
        settle();
        write_binning(1'b1);
        run_random(700, 1'b0);
        settle();
        write_binning(1'b0);
        run_random(425, 1'b1);
        settle();

        if (tracker.failures == 0 && tracker.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
